// ----- hdl/dhdl_pkg.sv -----
// Shared types, constants and the sequencer program for the decimated history delay lookup.
// Used by the channel interfaces, the sequencer, the datapath and the top level.
`default_nettype none

package dhdl_pkg;

    localparam int RING_DEPTH  = 20;
    localparam int GRID_POINTS = 16;
    localparam int RA_W        = $clog2(RING_DEPTH);
    localparam int GA_W        = $clog2(GRID_POINTS);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_TABLE = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] speed_sample;
        logic [15:0] pressure_sample;
        logic [3:0]  table_index;
        logic [15:0] grid_value;
        logic [7:0]  lag_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] delayed_speed;
        logic [15:0] delayed_pressure;
        logic [15:0] mean_pressure;
        logic [5:0]  lag_steps;
    } out_item_t;

    typedef logic [3:0] step_t;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_CNT_MORE = 2'd1,
        COND_NO_MATCH = 2'd2
    } cond_t;

    typedef enum logic {
        RSEL_PTR = 1'b0,
        RSEL_LAG = 1'b1
    } ring_sel_t;

    typedef enum logic {
        GSEL_LAST = 1'b0,
        GSEL_IDX  = 1'b1
    } grid_sel_t;

    // One control word per program step.
    typedef struct packed {
        logic      add_smp;
        logic      tbl_wr;
        logic      ptr_load;
        logic      ptr_dec;
        logic      acc_clr;
        logic      acc_add;
        logic      ring_rd;
        ring_sel_t ring_sel;
        logic      grid_rd;
        grid_sel_t grid_sel;
        logic      mean_ld;
        logic      idx_inc;
        logic      lag_ld;
        logic      emit;
        cond_t     cond;
        step_t     target;
        logic      last;
    } ctl_t;

    // Status returned from the datapath for jumps and output stalls.
    typedef struct packed {
        logic cnt_more;
        logic no_match;
        logic out_full;
    } dp_status_t;

    localparam ctl_t CTL_IDLE = ctl_t'('0);

    localparam step_t STEP_ADD   = 4'd0;
    localparam step_t STEP_TABLE = 4'd1;
    localparam step_t STEP_NOP   = 4'd2;
    localparam step_t STEP_QUERY = 4'd3;
    localparam step_t STEP_RLOOP = 4'd4;
    localparam step_t STEP_RACC  = 4'd5;
    localparam step_t STEP_GLAST = 4'd6;
    localparam step_t STEP_MEAN  = 4'd7;
    localparam step_t STEP_GSCAN = 4'd8;
    localparam step_t STEP_GCMP  = 4'd9;
    localparam step_t STEP_FOUND = 4'd10;
    localparam step_t STEP_EMIT  = 4'd11;

    // Program table. A step marked last ends the program; any other falls through to the next
    // one unless its condition holds, in which case it jumps to its target.
    function automatic ctl_t ucode_rom(input step_t step);
        ctl_t w;
        w = CTL_IDLE;
        case (step)
            STEP_ADD:
            begin
                w.add_smp = 1'b1;
                w.last    = 1'b1;
            end
            STEP_TABLE:
            begin
                w.tbl_wr = 1'b1;
                w.last   = 1'b1;
            end
            STEP_NOP:
            begin
                w.last = 1'b1;
            end
            STEP_QUERY:
            begin
                w.ptr_load = 1'b1;
                w.acc_clr  = 1'b1;
            end
            STEP_RLOOP:
            begin
                w.ring_rd  = 1'b1;
                w.ring_sel = RSEL_PTR;
                w.ptr_dec  = 1'b1;
            end
            STEP_RACC:
            begin
                w.acc_add = 1'b1;
                w.cond    = COND_CNT_MORE;
                w.target  = STEP_RLOOP;
            end
            STEP_GLAST:
            begin
                w.grid_rd  = 1'b1;
                w.grid_sel = GSEL_LAST;
            end
            STEP_MEAN:
            begin
                w.mean_ld = 1'b1;
            end
            STEP_GSCAN:
            begin
                w.grid_rd  = 1'b1;
                w.grid_sel = GSEL_IDX;
            end
            STEP_GCMP:
            begin
                w.lag_ld  = 1'b1;
                w.idx_inc = 1'b1;
                w.cond    = COND_NO_MATCH;
                w.target  = STEP_GSCAN;
            end
            STEP_FOUND:
            begin
                w.ring_rd  = 1'b1;
                w.ring_sel = RSEL_LAG;
            end
            STEP_EMIT:
            begin
                w.emit = 1'b1;
                w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dhdl_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on dhdl_pkg for the payload types.
`default_nettype none

interface dhdl_in_if
    import dhdl_pkg::*;
    ;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dhdl_out_if
    import dhdl_pkg::*;
    ;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dhdl_seq.sv -----
// Step counter and program fetch: dispatches on the command, follows jumps, stalls on output.
// Depends on dhdl_pkg for the control word, status struct and program table.
`default_nettype none

module dhdl_seq
    import dhdl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_cmd,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctl_t            ctl
);

    logic  busy_reg, busy_next;
    step_t step_reg, step_next;
    ctl_t  word;
    logic  stall;
    logic  run;
    logic  jump;
    logic  accept;
    step_t entry;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    assign word  = ucode_rom(step_reg);
    assign stall = word.emit && status.out_full;
    assign run   = busy_reg && !stall;
    assign ctl   = run ? word : CTL_IDLE;

    always_comb
    begin
        case (in_cmd)
            CMD_ADD:   entry = STEP_ADD;
            CMD_QUERY: entry = STEP_QUERY;
            CMD_TABLE: entry = STEP_TABLE;
            default:   entry = STEP_NOP;
        endcase
    end

    always_comb
    begin
        case (word.cond)
            COND_CNT_MORE: jump = status.cnt_more;
            COND_NO_MATCH: jump = status.no_match;
            default:       jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = entry;
        end
        else if (run)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
            end
            else if (jump)
            begin
                step_next = word.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_NOP;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("sequencer not busy after an accepted beat");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && stall) |=> (busy_reg && $stable(step_reg)))
        else $error("sequencer moved while the result register was full");

endmodule

`default_nettype wire

// ----- hdl/dhdl_datapath.sv -----
// Datapath driven by the control word: sample decimation, ring and grid stores,
// mean accumulator, grid scan and the result register. Depends on dhdl_pkg.
`default_nettype none

module dhdl_datapath
    import dhdl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire in_item_t  in_data,
    input  wire ctl_t      ctl,
    output dp_status_t     status,
    output logic           out_valid,
    output out_item_t      out_data,
    input  wire logic      out_ready
);

    localparam int LP_W = RA_W + 2;
    localparam int TI_W = GA_W + 4;

    in_item_t item_reg;

    // Decimation state.
    logic [17:0]     speed_sum_reg, speed_sum_next;
    logic [17:0]     pressure_sum_reg, pressure_sum_next;
    logic [1:0]      count_reg;
    logic [RA_W-1:0] wp_reg;
    logic            ring_we;

    // Ring store, one row per decimated pair; rows never written read as zero.
    logic [RING_DEPTH-1:0] rvalid_reg;
    logic [31:0]           ring_mem_reg [RING_DEPTH];
    logic [31:0]           ring_q_reg;
    logic [31:0]           ring_wdata;
    logic [RA_W-1:0]       ring_raddr;

    // Grid store, grid point and lag entry per row.
    logic [GRID_POINTS-1:0] gvalid_reg;
    logic [21:0]            grid_mem_reg [GRID_POINTS];
    logic [21:0]            grid_q_reg;
    logic [GA_W-1:0]        grid_raddr;
    logic [TI_W-1:0]        tidx;
    logic                   grid_we;
    logic [15:0]            grid_q_val;
    logic [5:0]             grid_q_lag;

    // Query working registers.
    logic [RA_W-1:0] ptr_reg;
    logic [18:0]     acc_reg;
    logic [2:0]      cnt_reg;
    logic [GA_W-1:0] idx_reg;
    logic [15:0]     mean_reg;
    logic [15:0]     mean_raw;
    logic [5:0]      lag_reg;
    logic [5:0]      lag_sat;
    logic [LP_W-1:0] lag_pos_full;
    logic [RA_W-1:0] lag_pos;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    assign grid_q_val = grid_q_reg[21:6];
    assign grid_q_lag = grid_q_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    // Sample decimation: every fourth sample closes a group and writes a ring row.
    assign speed_sum_next    = speed_sum_reg + 18'(item_reg.speed_sample);
    assign pressure_sum_next = pressure_sum_reg + 18'(item_reg.pressure_sample);
    assign ring_we           = ctl.add_smp && (count_reg == 2'd3);
    assign ring_wdata        = {speed_sum_next[17:2], pressure_sum_next[17:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_sum_reg    <= '0;
            pressure_sum_reg <= '0;
            count_reg        <= '0;
            wp_reg           <= '0;
            rvalid_reg       <= '0;
        end
        else if (ctl.add_smp)
        begin
            if (ring_we)
            begin
                speed_sum_reg      <= '0;
                pressure_sum_reg   <= '0;
                count_reg          <= '0;
                rvalid_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == RA_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            else
            begin
                speed_sum_reg    <= speed_sum_next;
                pressure_sum_reg <= pressure_sum_next;
                count_reg        <= count_reg + 1'b1;
            end
        end
    end

    // A lag of up to the ring depth steps back from the write position.
    assign lag_pos_full = LP_W'(wp_reg) + LP_W'(RING_DEPTH) - LP_W'(lag_reg);
    assign lag_pos = (lag_pos_full >= LP_W'(RING_DEPTH))
                   ? RA_W'(lag_pos_full - LP_W'(RING_DEPTH))
                   : RA_W'(lag_pos_full);
    assign ring_raddr = (ctl.ring_sel == RSEL_LAG) ? lag_pos : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem_reg[wp_reg] <= ring_wdata;
        end
        if (ctl.ring_rd)
        begin
            ring_q_reg <= rvalid_reg[ring_raddr] ? ring_mem_reg[ring_raddr] : '0;
        end
    end

    // Table writes beyond the grid are dropped.
    assign tidx       = TI_W'(item_reg.table_index);
    assign grid_we    = ctl.tbl_wr && (tidx < TI_W'(GRID_POINTS));
    assign grid_raddr = (ctl.grid_sel == GSEL_IDX) ? idx_reg : GA_W'(GRID_POINTS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvalid_reg <= '0;
        end
        else if (grid_we)
        begin
            gvalid_reg[tidx[GA_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem_reg[tidx[GA_W-1:0]] <= {item_reg.grid_value, item_reg.lag_byte[7:2]};
        end
        if (ctl.grid_rd)
        begin
            grid_q_reg <= gvalid_reg[grid_raddr] ? grid_mem_reg[grid_raddr] : '0;
        end
    end

    assign mean_raw = acc_reg[18:3];
    assign lag_sat  = (grid_q_lag > 6'(RING_DEPTH)) ? 6'(RING_DEPTH) : grid_q_lag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (ctl.ptr_load)
            begin
                ptr_reg <= wp_reg;
            end
            else if (ctl.ptr_dec)
            begin
                ptr_reg <= (ptr_reg == '0) ? RA_W'(RING_DEPTH - 1) : ptr_reg - 1'b1;
            end
            if (ctl.acc_clr)
            begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            else if (ctl.acc_add)
            begin
                acc_reg <= acc_reg + 19'(ring_q_reg[15:0]);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.mean_ld)
            begin
                idx_reg <= '0;
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mean_ld)
        begin
            mean_reg <= (mean_raw > grid_q_val) ? grid_q_val : mean_raw;
        end
        if (ctl.lag_ld)
        begin
            lag_reg <= lag_sat;
        end
    end

    assign status.cnt_more = (cnt_reg != 3'd7);
    assign status.no_match = !(mean_reg <= grid_q_val);
    assign status.out_full = out_valid_reg && !out_ready;

    // Result register: a new beat loads only when the previous one is gone or taken that cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_data_reg.delayed_speed    <= ring_q_reg[31:16];
            out_data_reg.delayed_pressure <= ring_q_reg[15:0];
            out_data_reg.mean_pressure    <= mean_reg;
            out_data_reg.lag_steps        <= lag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> out_valid_reg)
        else $error("result beat not presented after emit");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cond == COND_NO_MATCH && idx_reg == GA_W'(GRID_POINTS - 1)) |-> !status.no_match)
        else $error("grid scan ran past the last grid point");

    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg < RA_W'(RING_DEPTH)) && (wp_reg < RA_W'(RING_DEPTH)))
        else $error("ring pointer outside the ring");

endmodule

`default_nettype wire

// ----- hdl/decimated_history_delay_lookup_top.sv -----
// Top level of the decimated history delay lookup: sequencer plus datapath.
// Program: a sample or table beat runs its step after acceptance; a query sums eight ring rows
//   through the single ring read port, clamps their mean to the last grid point, scans the grid
//   for the first point not below the mean and reads the ring row at that point's lag to emit.
// Throughput: one step per cycle from the program table while the result register is not full. A
//   new beat is accepted the cycle after a program ends; a result waits in an output register.
// Reset: rst_n is asynchronous, active low, and clears sums, counters, write position and
//   the per-row valid bits, so every ring and grid row reads as zero at once.
`default_nettype none

module decimated_history_delay_lookup_top
    import dhdl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dhdl_in_if.sink    item,
    dhdl_out_if.source result
);

    ctl_t       ctl;
    dp_status_t status;
    logic       in_ready;
    logic       accept;

    assign item.ready = in_ready;
    assign accept     = item.valid && in_ready;

    dhdl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_cmd   (item.data.cmd),
        .in_ready (in_ready),
        .status   (status),
        .ctl      (ctl)
    );

    dhdl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (item.data),
        .ctl       (ctl),
        .status    (status),
        .out_valid (result.valid),
        .out_data  (result.data),
        .out_ready (result.ready)
    );

endmodule

`default_nettype wire
